/* sv/bitcoin_tx_stream_parser_assert.svh */
// assertion macros for the transaction stream parser
`ifndef BITCOIN_TX_STREAM_PARSER_ASSERT_SVH
`define BITCOIN_TX_STREAM_PARSER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BTP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define BTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/btp_pkg.sv */
// package for the transaction stream parser: types, phases and token codes
`default_nettype none
package btp_pkg;

    localparam int TXID_BYTES = 32;
    localparam int QDEPTH = 4;

    typedef enum logic [4:0] {
        PH_VER, PH_MARK0, PH_MARK1, PH_INCOUNT, PH_TXID, PH_PREVIDX, PH_INSLEN,
        PH_INSBYTE, PH_SEQ, PH_OUTCOUNT, PH_AMOUNT, PH_OSLEN, PH_OSBYTE,
        PH_WITCOUNT, PH_WITLEN, PH_WITBYTE, PH_LOCK, PH_DONE, PH_DRAIN
    } phase_t;

    localparam logic [4:0] TK_VERSION = 5'd0;
    localparam logic [4:0] TK_MARKER = 5'd1;
    localparam logic [4:0] TK_INCOUNT = 5'd2;
    localparam logic [4:0] TK_TXIDBYTE = 5'd3;
    localparam logic [4:0] TK_PREVINDEX = 5'd4;
    localparam logic [4:0] TK_INSCRIPTLEN = 5'd5;
    localparam logic [4:0] TK_INSCRIPTBYTE = 5'd6;
    localparam logic [4:0] TK_SEQUENCE = 5'd7;
    localparam logic [4:0] TK_OUTCOUNT = 5'd8;
    localparam logic [4:0] TK_AMOUNT = 5'd9;
    localparam logic [4:0] TK_OUTSCRIPTLEN = 5'd10;
    localparam logic [4:0] TK_OUTSCRIPTBYTE = 5'd11;
    localparam logic [4:0] TK_WITCOUNT = 5'd12;
    localparam logic [4:0] TK_WITLEN = 5'd13;
    localparam logic [4:0] TK_WITBYTE = 5'd14;
    localparam logic [4:0] TK_LOCKTIME = 5'd15;
    localparam logic [4:0] TK_STATUS = 5'd16;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_TRAIL = 2'd2;
    localparam logic [1:0] ST_BIG = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [63:0] token_value;
        logic [31:0] entry_number;
        logic [31:0] stack_item_number;
        logic [1:0]  end_status;
        logic        last_of_run;
    } out_item_t;

    // one queued token as produced by the front part
    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] value;
        logic [31:0] entry;
        logic [31:0] item;
        logic        last;
    } tok_t;

    // up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0] count;
        tok_t [2:0] toks;
    } bundle_t;

    function automatic out_item_t tok_to_out(tok_t t);
        out_item_t o;
        o.token_kind = t.kind;
        o.token_value = t.value;
        o.entry_number = t.entry;
        o.stack_item_number = t.item;
        o.end_status = (t.kind == TK_STATUS) ? t.value[1:0] : ST_OK;
        o.last_of_run = t.last;
        return o;
    endfunction

endpackage
`default_nettype wire

/* sv/bitcoin_tx_stream_parser.sv */
// top level of the transaction stream parser
//  channel   | direction | payload      | handshake
//  in        | in        | in_item_t    | in_valid / in_ready
//  out       | out       | out_item_t   | out_valid / out_ready
// A byte is taken and turned into up to three tokens at once.
// Tokens drain one per cycle while the output is taken, from a four-entry queue
// into the output register, so bytes with one token sustain one per cycle.
// Reset clears the field state and queue at once; no clearing pass.
// A stalled output fills the queue and then drops in_ready.
`default_nettype none
module bitcoin_tx_stream_parser #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire btp_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output btp_pkg::out_item_t      out_data
);
    import btp_pkg::*;

    bundle_t bundle;
    logic    step;

    assign step = in_valid && in_ready;

    // front: field state machine
    btp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .in_item(in_data), .bundle(bundle)
    );

    // back: token queue and output register
    btp_back u_back (
        .clk(clk), .rst_n(rst_n), .push(step), .bundle(bundle), .space(in_ready),
        .valid(out_valid), .ready(out_ready), .item(out_data)
    );

`include "bitcoin_tx_stream_parser_assert.svh"

    `BTP_ASSERT_IMPLY(a_status_last, out_valid && out_data.token_kind == TK_STATUS,
        out_data.last_of_run, "status token not last of run")
    `BTP_ASSERT_IMPLY(a_byte_has_token, step, bundle.count != 2'd0 || !in_data.final_byte,
        "final byte produced no token")
    `BTP_ASSERT_NEXT(a_final_closes, step && in_data.final_byte,
        u_front.phase_reg == PH_VER, "parser not reset after final byte")

endmodule
`default_nettype wire

/* sv/btp_front.sv */
// front part: field state machine, turns one byte into a bundle of tokens
`default_nettype none
module btp_front #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire btp_pkg::in_item_t in_item,
    output btp_pkg::bundle_t      bundle
);
    import btp_pkg::*;

    localparam logic [63:0] LIMIT = (COUNT_BITS >= 32) ? 64'hFFFF_FFFF
                                    : ((64'd1 << COUNT_BITS) - 64'd1);

    phase_t      phase_reg, phase_next;
    logic [5:0]  fbc_reg, fbc_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] intot_reg, intot_next;
    logic [31:0] ent_reg, ent_next;
    logic [31:0] outtot_reg, outtot_next;
    logic [31:0] wtot_reg, wtot_next;
    logic [31:0] widx_reg, widx_next;
    logic        seg_reg, seg_next;
    logic        held_reg, held_next;
    logic [1:0]  err_reg, err_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VER;
            fbc_reg <= '0;
            acc_reg <= '0;
            left_reg <= '0;
            intot_reg <= '0;
            ent_reg <= '0;
            outtot_reg <= '0;
            wtot_reg <= '0;
            widx_reg <= '0;
            seg_reg <= 1'b0;
            held_reg <= 1'b0;
            err_reg <= ST_OK;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            fbc_reg <= fbc_next;
            acc_reg <= acc_next;
            left_reg <= left_next;
            intot_reg <= intot_next;
            ent_reg <= ent_next;
            outtot_reg <= outtot_next;
            wtot_reg <= wtot_next;
            widx_reg <= widx_next;
            seg_reg <= seg_next;
            held_reg <= held_next;
            err_reg <= err_next;
        end
    end

    // one byte through the field machine, with one replay for the held zero
    always_comb
    begin
        logic [7:0]  b;
        logic [1:0]  n;
        logic        redo;
        logic        cdone;
        logic [63:0] v;
        logic [4:0]  k;
        logic [31:0] e;
        logic [31:0] it;
        logic [1:0]  st;
        logic [2:0]  sh;
        phase_next = phase_reg;
        fbc_next = fbc_reg;
        acc_next = acc_reg;
        left_next = left_reg;
        intot_next = intot_reg;
        ent_next = ent_reg;
        outtot_next = outtot_reg;
        wtot_next = wtot_reg;
        widx_next = widx_reg;
        seg_next = seg_reg;
        held_next = held_reg;
        err_next = err_reg;
        bundle = '0;
        n = 2'd0;
        b = in_item.data_byte;
        redo = 1'b0;
        cdone = 1'b0;
        v = '0;
        k = '0;
        e = '0;
        it = '0;
        st = ST_OK;
        sh = '0;

        // marker lookahead resolution, held zero waits in the marker phase
        if (held_reg)
        begin
            held_next = 1'b0;
            phase_next = PH_INCOUNT;
            if (b == 8'h01)
            begin
                seg_next = 1'b1;
                bundle.toks[0] = '{TK_MARKER, 64'd1, 32'd0, 32'd0, 1'b0};
                n = 2'd1;
            end
            else
            begin
                // held zero is an input count of zero
                bundle.toks[0] = '{TK_INCOUNT, 64'd0, 32'd0, 32'd0, 1'b0};
                n = 2'd1;
                intot_next = '0;
                ent_next = '0;
                phase_next = PH_OUTCOUNT;
                redo = 1'b1;
            end
        end

        if (!held_reg || redo)
        begin
            case (phase_next)
                PH_VER, PH_PREVIDX, PH_SEQ, PH_AMOUNT, PH_LOCK:
                begin
                    sh = fbc_next[2:0];
                    acc_next = acc_next | (64'(b) << {sh, 3'b000});
                    fbc_next = fbc_next + 6'd1;
                    if (fbc_next >= ((phase_next == PH_AMOUNT) ? 6'd8 : 6'd4))
                    begin
                        v = acc_next;
                        acc_next = '0;
                        fbc_next = '0;
                        left_next = '0;
                        case (phase_next)
                            PH_VER:
                            begin
                                bundle.toks[n] = '{TK_VERSION, v, 32'd0, 32'd0, 1'b0};
                                phase_next = PH_MARK0;
                            end
                            PH_PREVIDX:
                            begin
                                bundle.toks[n] = '{TK_PREVINDEX, v, ent_next, 32'd0, 1'b0};
                                phase_next = PH_INSLEN;
                            end
                            PH_SEQ:
                            begin
                                bundle.toks[n] = '{TK_SEQUENCE, v, ent_next, 32'd0, 1'b0};
                                ent_next = ent_next + 32'd1;
                                if (ent_next >= intot_next)
                                begin
                                    ent_next = '0;
                                    phase_next = PH_OUTCOUNT;
                                end
                                else
                                    phase_next = PH_TXID;
                            end
                            PH_AMOUNT:
                            begin
                                bundle.toks[n] = '{TK_AMOUNT, v, ent_next, 32'd0, 1'b0};
                                phase_next = PH_OSLEN;
                            end
                            default:
                            begin
                                bundle.toks[n] = '{TK_LOCKTIME, v, 32'd0, 32'd0, 1'b0};
                                phase_next = PH_DONE;
                            end
                        endcase
                        n = n + 2'd1;
                    end
                end
                PH_MARK0, PH_INCOUNT, PH_INSLEN, PH_OUTCOUNT, PH_OSLEN, PH_WITCOUNT,
                PH_WITLEN:
                begin
                    if (phase_next == PH_MARK0 && b == 8'h00 && !in_item.final_byte)
                    begin
                        held_next = 1'b1;
                        phase_next = PH_MARK1;
                    end
                    else
                    begin
                        if (phase_next == PH_MARK0)
                            phase_next = PH_INCOUNT;
                        // compact size byte
                        if (fbc_next == 6'd0)
                        begin
                            if (b < 8'hFD)
                            begin
                                acc_next = 64'(b);
                                cdone = 1'b1;
                            end
                            else
                            begin
                                left_next = (b == 8'hFD) ? 32'd2
                                          : (b == 8'hFE) ? 32'd4 : 32'd8;
                                acc_next = '0;
                                fbc_next = 6'd1;
                            end
                        end
                        else
                        begin
                            sh = 3'(fbc_next - 6'd1);
                            acc_next = acc_next | (64'(b) << {sh, 3'b000});
                            fbc_next = fbc_next + 6'd1;
                            cdone = (32'(fbc_next - 6'd1) >= left_next);
                        end
                        if (cdone)
                        begin
                            v = acc_next;
                            acc_next = '0;
                            fbc_next = '0;
                            left_next = '0;
                            e = ent_next;
                            it = '0;
                            case (phase_next)
                                PH_INCOUNT: begin k = TK_INCOUNT; e = '0; end
                                PH_INSLEN: k = TK_INSCRIPTLEN;
                                PH_OUTCOUNT: begin k = TK_OUTCOUNT; e = '0; end
                                PH_OSLEN: k = TK_OUTSCRIPTLEN;
                                PH_WITCOUNT: k = TK_WITCOUNT;
                                default: begin k = TK_WITLEN; it = widx_next; end
                            endcase
                            bundle.toks[n] = '{k, v, e, it, 1'b0};
                            n = n + 2'd1;
                            if (v > LIMIT)
                            begin
                                err_next = ST_BIG;
                                phase_next = PH_DRAIN;
                            end
                            else
                            begin
                                case (phase_next)
                                    PH_INCOUNT:
                                    begin
                                        intot_next = v[31:0];
                                        ent_next = '0;
                                        phase_next = (v == 0) ? PH_OUTCOUNT : PH_TXID;
                                    end
                                    PH_INSLEN:
                                    begin
                                        left_next = v[31:0];
                                        phase_next = (v == 0) ? PH_SEQ : PH_INSBYTE;
                                    end
                                    PH_OUTCOUNT:
                                    begin
                                        outtot_next = v[31:0];
                                        ent_next = '0;
                                        if (v == 0)
                                            phase_next = (seg_next && intot_next != 0)
                                                       ? PH_WITCOUNT : PH_LOCK;
                                        else
                                            phase_next = PH_AMOUNT;
                                    end
                                    PH_OSLEN:
                                    begin
                                        left_next = v[31:0];
                                        if (v == 0)
                                        begin
                                            ent_next = ent_next + 32'd1;
                                            if (ent_next >= outtot_next)
                                            begin
                                                ent_next = '0;
                                                phase_next = (seg_next && intot_next != 0)
                                                           ? PH_WITCOUNT : PH_LOCK;
                                            end
                                            else
                                                phase_next = PH_AMOUNT;
                                        end
                                        else
                                            phase_next = PH_OSBYTE;
                                    end
                                    PH_WITCOUNT:
                                    begin
                                        wtot_next = v[31:0];
                                        widx_next = '0;
                                        if (v == 0)
                                        begin
                                            ent_next = ent_next + 32'd1;
                                            if (ent_next >= intot_next)
                                            begin
                                                ent_next = '0;
                                                phase_next = PH_LOCK;
                                            end
                                            else
                                                phase_next = PH_WITCOUNT;
                                        end
                                        else
                                            phase_next = PH_WITLEN;
                                    end
                                    default:
                                    begin
                                        left_next = v[31:0];
                                        if (v == 0)
                                        begin
                                            widx_next = widx_next + 32'd1;
                                            if (widx_next >= wtot_next)
                                            begin
                                                ent_next = ent_next + 32'd1;
                                                if (ent_next >= intot_next)
                                                begin
                                                    ent_next = '0;
                                                    phase_next = PH_LOCK;
                                                end
                                                else
                                                    phase_next = PH_WITCOUNT;
                                            end
                                            else
                                                phase_next = PH_WITLEN;
                                        end
                                        else
                                            phase_next = PH_WITBYTE;
                                    end
                                endcase
                            end
                        end
                    end
                end
                PH_TXID:
                begin
                    bundle.toks[n] = '{TK_TXIDBYTE, 64'(b), ent_next, 32'd0, 1'b0};
                    n = n + 2'd1;
                    fbc_next = fbc_next + 6'd1;
                    if (fbc_next >= 6'(TXID_BYTES))
                    begin
                        fbc_next = '0;
                        phase_next = PH_PREVIDX;
                    end
                end
                PH_INSBYTE:
                begin
                    bundle.toks[n] = '{TK_INSCRIPTBYTE, 64'(b), ent_next, 32'd0, 1'b0};
                    n = n + 2'd1;
                    left_next = left_next - 32'd1;
                    if (left_next == 0)
                        phase_next = PH_SEQ;
                end
                PH_OSBYTE:
                begin
                    bundle.toks[n] = '{TK_OUTSCRIPTBYTE, 64'(b), ent_next, 32'd0, 1'b0};
                    n = n + 2'd1;
                    left_next = left_next - 32'd1;
                    if (left_next == 0)
                    begin
                        ent_next = ent_next + 32'd1;
                        if (ent_next >= outtot_next)
                        begin
                            ent_next = '0;
                            phase_next = (seg_next && intot_next != 0) ? PH_WITCOUNT : PH_LOCK;
                        end
                        else
                            phase_next = PH_AMOUNT;
                    end
                end
                PH_WITBYTE:
                begin
                    bundle.toks[n] = '{TK_WITBYTE, 64'(b), ent_next, widx_next, 1'b0};
                    n = n + 2'd1;
                    left_next = left_next - 32'd1;
                    if (left_next == 0)
                    begin
                        widx_next = widx_next + 32'd1;
                        if (widx_next >= wtot_next)
                        begin
                            ent_next = ent_next + 32'd1;
                            if (ent_next >= intot_next)
                            begin
                                ent_next = '0;
                                phase_next = PH_LOCK;
                            end
                            else
                                phase_next = PH_WITCOUNT;
                        end
                        else
                            phase_next = PH_WITLEN;
                    end
                end
                PH_DONE:
                begin
                    err_next = ST_TRAIL;
                    phase_next = PH_DRAIN;
                end
                default:
                begin
                end
            endcase
        end

        // closing status on the final byte, then back to reset state
        if (in_item.final_byte)
        begin
            if (err_next != ST_OK)
                st = err_next;
            else
                st = (phase_next == PH_DONE) ? ST_OK : ST_TRUNC;
            bundle.toks[n] = '{TK_STATUS, 64'(st), 32'd0, 32'd0, 1'b0};
            n = n + 2'd1;
            phase_next = PH_VER;
            fbc_next = '0;
            acc_next = '0;
            left_next = '0;
            intot_next = '0;
            ent_next = '0;
            outtot_next = '0;
            wtot_next = '0;
            widx_next = '0;
            seg_next = 1'b0;
            held_next = 1'b0;
            err_next = ST_OK;
        end

        // mark last token of the byte
        case (n)
            2'd1: bundle.toks[0].last = 1'b1;
            2'd2: bundle.toks[1].last = 1'b1;
            2'd3: bundle.toks[2].last = 1'b1;
            default: ;
        endcase
        bundle.count = n;
    end

endmodule
`default_nettype wire

/* sv/btp_back.sv */
// back part: token queue and serializer to the output register
`default_nettype none
module btp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire btp_pkg::bundle_t  bundle,
    output logic                   space,
    output logic                   valid,
    input  wire logic              ready,
    output btp_pkg::out_item_t     item
);
    import btp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    tok_t          mem [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          ov_reg;
    out_item_t     out_reg;
    logic          pop;
    logic [1:0]    npush;

    assign npush = push ? bundle.count : 2'd0;
    // output register loads when the queue holds a token and the register is empty or being taken
    assign pop = (cnt_reg != 0) && (!ov_reg || ready);
    assign cnt_next = cnt_reg + (PW+1)'(npush) - (PW+1)'(pop);
    // room for a worst case bundle after this cycle
    assign space = (cnt_reg <= (PW+1)'(QDEPTH - 3)) ||
                   (pop && cnt_reg == (PW+1)'(QDEPTH - 2));
    assign valid = ov_reg;
    assign item = out_reg;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (npush != 0)
            mem[wp_reg] <= bundle.toks[0];
        if (npush >= 2'd2)
            mem[PW'(wp_reg + PW'(1))] <= bundle.toks[1];
        if (npush == 2'd3)
            mem[PW'(wp_reg + PW'(2))] <= bundle.toks[2];
        if (pop)
            out_reg <= tok_to_out(mem[rp_reg]);
    end

    // pointers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            wp_reg <= wp_reg + PW'(npush);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_next;
            if (pop)
                ov_reg <= 1'b1;
            else if (ready)
                ov_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* verif/tb_bitcoin_tx_stream_parser.sv */
// testbench for the transaction stream parser: random byte streams checked against a token predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_bitcoin_tx_stream_parser;
    import btp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    // token store and comparison
    class token_scoreboard;
        out_item_t pending[$];
        int errors;

        function void note_request(out_item_t toks[$]);
            foreach (toks[i]) pending.push_back(toks[i]);
        endfunction

        function void check_token(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $error("token with none expected: kind %0d value %0h",
                    got.token_kind, got.token_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind: expected %0d actual %0d", want.token_kind, got.token_kind);
                errors++;
            end
            if (got.token_value !== want.token_value) begin
                $error("token_value: expected %0h actual %0h", want.token_value, got.token_value);
                errors++;
            end
            if (got.entry_number !== want.entry_number) begin
                $error("entry_number: expected %0d actual %0d",
                    want.entry_number, got.entry_number);
                errors++;
            end
            if (got.stack_item_number !== want.stack_item_number) begin
                $error("stack_item_number: expected %0d actual %0d",
                    want.stack_item_number, got.stack_item_number);
                errors++;
            end
            if (got.end_status !== want.end_status) begin
                $error("end_status: expected %0d actual %0d", want.end_status, got.end_status);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d actual %0d",
                    want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    bitcoin_tx_stream_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    token_scoreboard sb;
    int idle_cycles;
    bit timed_out;

    // predictor state
    phase_t      ph;
    int unsigned fcount;
    logic [63:0] facc;
    logic [31:0] pleft;
    logic [31:0] n_in;
    logic [31:0] ent;
    logic [31:0] n_out;
    logic [31:0] n_wit;
    logic [31:0] wit_idx;
    logic        segwit;
    logic [1:0]  err;
    out_item_t   toks[$];

    function automatic void parser_clear();
        ph = PH_VER; fcount = 0; facc = '0; pleft = '0; n_in = '0; ent = '0;
        n_out = '0; n_wit = '0; wit_idx = '0; segwit = 0; err = ST_OK;
    endfunction

    function automatic void push_token(logic [4:0] k, logic [63:0] v,
                                       logic [31:0] e, logic [31:0] it);
        out_item_t o;
        o.token_kind = k; o.token_value = v; o.entry_number = e;
        o.stack_item_number = it;
        o.end_status = (k == TK_STATUS) ? v[1:0] : ST_OK;
        o.last_of_run = 0;
        toks.push_back(o);
    endfunction

    // little-endian fixed field, true when complete
    function automatic bit fixed_field(logic [7:0] b, int unsigned len);
        facc |= 64'(b) << (8 * (fcount & 7));
        fcount++;
        return fcount >= len;
    endfunction

    function automatic logic [63:0] take_value();
        logic [63:0] v;
        v = facc; facc = '0; fcount = 0; pleft = '0;
        return v;
    endfunction

    function automatic void after_outputs();
        ent = 0;
        ph = (segwit && n_in != 0) ? PH_WITCOUNT : PH_LOCK;
    endfunction

    function automatic void next_output();
        ent++;
        if (ent >= n_out) after_outputs(); else ph = PH_AMOUNT;
    endfunction

    function automatic void next_wit_input();
        ent++;
        if (ent >= n_in) begin ent = 0; ph = PH_LOCK; end
        else ph = PH_WITCOUNT;
    endfunction

    function automatic void next_wit_item();
        wit_idx++;
        if (wit_idx >= n_wit) next_wit_input(); else ph = PH_WITLEN;
    endfunction

    // compact size byte
    function automatic void count_step(logic [7:0] b);
        logic [63:0] v;
        logic [4:0] k;
        logic [31:0] e;
        logic [31:0] it;
        if (fcount == 0) begin
            if (b < 8'hFD) facc = 64'(b);
            else begin
                pleft = (b == 8'hFD) ? 2 : (b == 8'hFE) ? 4 : 8;
                facc = '0; fcount = 1;
                return;
            end
        end else begin
            facc |= 64'(b) << (8 * ((fcount - 1) & 7));
            fcount++;
            if (fcount - 1 < pleft) return;
        end
        v = take_value();
        e = ent; it = 0;
        case (ph)
            PH_INCOUNT:  begin k = TK_INCOUNT; e = 0; end
            PH_INSLEN:   k = TK_INSCRIPTLEN;
            PH_OUTCOUNT: begin k = TK_OUTCOUNT; e = 0; end
            PH_OSLEN:    k = TK_OUTSCRIPTLEN;
            PH_WITCOUNT: k = TK_WITCOUNT;
            default:     begin k = TK_WITLEN; it = wit_idx; end
        endcase
        push_token(k, v, e, it);
        if (v > 64'hFFFF_FFFF) begin err = ST_BIG; ph = PH_DRAIN; return; end
        case (ph)
            PH_INCOUNT: begin
                n_in = v[31:0]; ent = 0;
                ph = (v == 0) ? PH_OUTCOUNT : PH_TXID;
            end
            PH_INSLEN: begin
                pleft = v[31:0];
                ph = (v == 0) ? PH_SEQ : PH_INSBYTE;
            end
            PH_OUTCOUNT: begin
                n_out = v[31:0]; ent = 0;
                if (v == 0) after_outputs(); else ph = PH_AMOUNT;
            end
            PH_OSLEN: begin
                pleft = v[31:0];
                if (v == 0) next_output(); else ph = PH_OSBYTE;
            end
            PH_WITCOUNT: begin
                n_wit = v[31:0]; wit_idx = 0;
                if (v == 0) next_wit_input(); else ph = PH_WITLEN;
            end
            default: begin
                pleft = v[31:0];
                if (v == 0) next_wit_item(); else ph = PH_WITBYTE;
            end
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b, bit fin);
        logic [63:0] v;
        case (ph)
            PH_VER: if (fixed_field(b, 4)) begin
                v = take_value(); push_token(TK_VERSION, v, 0, 0); ph = PH_MARK0;
            end
            PH_MARK0: begin
                if (b == 0 && !fin) ph = PH_MARK1;
                else begin ph = PH_INCOUNT; count_step(b); end
            end
            PH_MARK1: begin
                ph = PH_INCOUNT;
                if (b == 1) begin segwit = 1; push_token(TK_MARKER, 64'd1, 0, 0); end
                else begin count_step(8'h00); parse_byte(b, fin); end
            end
            PH_INCOUNT, PH_INSLEN, PH_OUTCOUNT, PH_OSLEN, PH_WITCOUNT, PH_WITLEN:
                count_step(b);
            PH_TXID: begin
                push_token(TK_TXIDBYTE, 64'(b), ent, 0);
                fcount++;
                if (fcount >= TXID_BYTES) begin fcount = 0; ph = PH_PREVIDX; end
            end
            PH_PREVIDX: if (fixed_field(b, 4)) begin
                v = take_value(); push_token(TK_PREVINDEX, v, ent, 0); ph = PH_INSLEN;
            end
            PH_INSBYTE: begin
                push_token(TK_INSCRIPTBYTE, 64'(b), ent, 0);
                pleft--;
                if (pleft == 0) ph = PH_SEQ;
            end
            PH_SEQ: if (fixed_field(b, 4)) begin
                v = take_value(); push_token(TK_SEQUENCE, v, ent, 0);
                ent++;
                if (ent >= n_in) begin ent = 0; ph = PH_OUTCOUNT; end
                else ph = PH_TXID;
            end
            PH_AMOUNT: if (fixed_field(b, 8)) begin
                v = take_value(); push_token(TK_AMOUNT, v, ent, 0); ph = PH_OSLEN;
            end
            PH_OSBYTE: begin
                push_token(TK_OUTSCRIPTBYTE, 64'(b), ent, 0);
                pleft--;
                if (pleft == 0) next_output();
            end
            PH_WITBYTE: begin
                push_token(TK_WITBYTE, 64'(b), ent, wit_idx);
                pleft--;
                if (pleft == 0) next_wit_item();
            end
            PH_LOCK: if (fixed_field(b, 4)) begin
                v = take_value(); push_token(TK_LOCKTIME, v, 0, 0); ph = PH_DONE;
            end
            PH_DONE: begin err = ST_TRAIL; ph = PH_DRAIN; end
            default: ;
        endcase
    endfunction

    // expected tokens for one accepted byte
    function automatic void predict_tokens(in_item_t it);
        logic [1:0] st;
        toks.delete();
        parse_byte(it.data_byte, it.final_byte);
        if (it.final_byte) begin
            if (err != ST_OK) st = err;
            else st = (ph == PH_DONE) ? ST_OK : ST_TRUNC;
            push_token(TK_STATUS, 64'(st), 0, 0);
            parser_clear();
        end
        if (toks.size() > 0) toks[toks.size() - 1].last_of_run = 1;
    endfunction

    // stimulus bytes, built as whole transactions
    in_item_t stim[$];

    function automatic void add_byte(logic [7:0] b);
        in_item_t x;
        x.data_byte = b; x.final_byte = 0;
        stim.push_back(x);
    endfunction

    function automatic void add_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
    endfunction

    function automatic void add_compact(int unsigned v);
        int r;
        r = $urandom_range(0, 5);
        if (v < 253 && r < 4) add_byte(v[7:0]);
        else if (v < 65536 && r < 5) begin add_byte(8'hFD); add_le(64'(v), 2); end
        else if (r == 5) begin add_byte(8'hFF); add_le(64'(v), 8); end
        else begin add_byte(8'hFE); add_le(64'(v), 4); end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one well-formed transaction, small sizes
    function automatic void add_tx(bit sw, int unsigned nin, int unsigned nout);
        int unsigned n;
        add_le({32'h0, $urandom()}, 4);
        if (sw) begin add_byte(8'h00); add_byte(8'h01); end
        add_compact(nin);
        for (int i = 0; i < nin; i++) begin
            for (int j = 0; j < TXID_BYTES; j++) add_byte(8'($urandom_range(0, 255)));
            add_le({32'h0, $urandom()}, 4);
            n = $urandom_range(0, 3);
            add_compact(n);
            for (int j = 0; j < n; j++) add_byte(8'($urandom_range(0, 255)));
            add_le({32'h0, $urandom()}, 4);
        end
        add_compact(nout);
        for (int i = 0; i < nout; i++) begin
            add_le(rand64(), 8);
            n = $urandom_range(0, 3);
            add_compact(n);
            for (int j = 0; j < n; j++) add_byte(8'($urandom_range(0, 255)));
        end
        if (sw) for (int i = 0; i < nin; i++) begin
            n = $urandom_range(0, 2);
            add_compact(n);
            for (int j = 0; j < n; j++) begin
                int unsigned l;
                l = $urandom_range(0, 3);
                add_compact(l);
                for (int k = 0; k < l; k++) add_byte(8'($urandom_range(0, 255)));
            end
        end
        add_le({32'h0, $urandom()}, 4);
    endfunction

    function automatic void mark_final();
        stim[stim.size() - 1].final_byte = 1;
    endfunction

    // clock
    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // random gap length, mostly short, sometimes long
    function automatic int gap_length();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    // send one request and wait for its acceptance
    task automatic send_byte(in_item_t x);
        in_valid <= 1;
        in_data <= x;
        do @(posedge clk); while (!in_ready);
        predict_tokens(x);
        sb.note_request(toks);
        @(negedge clk);
    endtask

    // drop valid and let a clock pass
    task automatic input_idle();
        in_valid <= 0;
        @(negedge clk);
    endtask

    task automatic send_all();
        while (stim.size() > 0) begin
            int n;
            send_byte(stim.pop_front());
            n = 0;
            if ($urandom_range(0, 2) == 0) n = gap_length();
            if (n > 0) begin
                in_valid <= 0;
                repeat (n) @(negedge clk);
            end
        end
    endtask

    // output side: random ready, check on rising edge
    initial begin
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 9) == 0) begin
                out_ready <= 0;
                repeat ($urandom_range(3, 25)) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_token(out_data);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        sb = new();
        parser_clear();
        timed_out = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: unconfirmed marker, version ending on the final byte, final zero byte
        add_le(32'hFFFF_FFFF, 4); add_byte(8'h00); add_byte(8'h05); mark_final();
        add_le(32'h0000_0000, 3); add_byte(8'h00); mark_final();
        add_le(32'h1, 4); add_byte(8'h00); mark_final();
        // segwit with no inputs, then trailing data
        add_le(32'h2, 4); add_byte(8'h00); add_byte(8'h01); add_byte(8'h00);
        add_byte(8'h00); add_le(32'hFFFF_FFFF, 4); add_byte(8'hAA); add_byte(8'h55);
        mark_final();
        // oversized count
        add_le(32'h1, 4); add_byte(8'hFF); add_le(64'hFFFF_FFFF_0000_0001, 8);
        add_byte(8'h12); mark_final();
        // count just at the limit, then truncated
        add_le(32'h1, 4); add_byte(8'hFE); add_le(32'hFFFF_FFFF, 4); mark_final();
        send_all();

        // directed full segwit transaction with one input
        add_tx(1, 1, 0); mark_final();
        send_all();
        input_idle();

        // hold off until every token has drained
        while (sb.pending.size() > 0 && idle_cycles < WATCHDOG_LIMIT) @(negedge clk);

        // random: small transactions, some cut short, trailing or noise
        for (int t = 0; t < 2; t++) begin
            int r;
            r = $urandom_range(0, 9);
            add_tx(1'($urandom_range(0, 1)), 0, $urandom_range(0, 1));
            if (r == 0) begin
                int cut;
                cut = $urandom_range(1, stim.size() - 1);
                while (stim.size() > cut) void'(stim.pop_back());
            end else if (r == 1) add_byte(8'($urandom_range(0, 255)));
            else if (r == 2) begin
                stim.delete();
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            end
            mark_final();
            send_all();
        end
        input_idle();

        // wait for the queue to empty
        while (sb.pending.size() > 0 && idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
        if (sb.pending.size() > 0) timed_out = 1;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (timed_out) begin
            $display("FAILED: results differ");
        end else if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // stuck run
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
